// ===== rtl/packed_pixel_palette_unpacker_unit_macros.svh =====
// Assertion macros for the unpacker RTL, included by ppu_seq.
`ifndef PACKED_PIXEL_PALETTE_UNPACKER_UNIT_MACROS_SVH
`define PACKED_PIXEL_PALETTE_UNPACKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PPU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ppu assertion failed");
`define PPU_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ppu assertion failed");
`else
`define PPU_ASSERT(name, clk, rst, prop)
`define PPU_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/ppu_pkg.sv =====
package ppu_pkg;

   localparam int PALETTE_COUNT      = 256;
   localparam int MAX_BITS_PER_PIXEL = 4;
   localparam int ENTRY_COUNT        = 1 << MAX_BITS_PER_PIXEL;
   localparam int STORE_DEPTH        = PALETTE_COUNT * ENTRY_COUNT;
   localparam int ADDR_BITS          = $clog2(STORE_DEPTH);

   localparam int DATA_BITS  = 8;
   localparam int PAL_BITS   = 8;
   localparam int INDEX_BITS = 4;
   localparam int FIELD_BITS = 4;
   localparam int LEFT_BITS  = 4;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic REG_BPP = 1'b0;

   localparam logic [1:0] BPP_CODE_1   = 2'd0;
   localparam logic [1:0] BPP_CODE_2   = 2'd1;
   localparam logic [1:0] BPP_CODE_4   = 2'd2;
   localparam logic [1:0] BPP_CODE_RST = BPP_CODE_4;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] addr;
      logic                 zero;
      logic                 last;
   } rd_req_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [DATA_BITS-1:0] data;
   } wr_req_type;

   function automatic logic [LEFT_BITS-1:0] bpp_count(input logic [1:0] code);
      logic [LEFT_BITS-1:0] n;
      unique case (code)
         BPP_CODE_1: n = 4'd8;
         BPP_CODE_2: n = 4'd4;
         default:    n = 4'd2;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] bpp_width(input logic [1:0] code);
      logic [2:0] w;
      unique case (code)
         BPP_CODE_1: w = 3'd1;
         BPP_CODE_2: w = 3'd2;
         default:    w = 3'd4;
      endcase
      return w;
   endfunction

   function automatic logic [FIELD_BITS-1:0] top_field(input logic [DATA_BITS-1:0] b,
                                                       input logic [1:0] code);
      logic [FIELD_BITS-1:0] f;
      unique case (code)
         BPP_CODE_1: f = {3'b000, b[7]};
         BPP_CODE_2: f = {2'b00, b[7:6]};
         default:    f = b[7:4];
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/ppu_req_if.sv =====
interface ppu_req_if import ppu_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [PAL_BITS-1:0]   palette_select;
   logic [INDEX_BITS-1:0] entry_index;
   logic [DATA_BITS-1:0]  entry_value;
   logic [DATA_BITS-1:0]  packed_byte;

   modport source (output valid, command, palette_select, entry_index, entry_value,
                   packed_byte, input ready);
   modport sink (input valid, command, palette_select, entry_index, entry_value,
                 packed_byte, output ready);
endinterface

// ===== rtl/ppu_rsp_if.sv =====
interface ppu_rsp_if import ppu_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] pixel_color;
   logic                 last_of_byte;

   modport source (output valid, pixel_color, last_of_byte, input ready);
   modport sink (input valid, pixel_color, last_of_byte, output ready);
endinterface

// ===== rtl/ppu_csr.sv =====
module ppu_csr import ppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [1:0]               bpp_code
);

   logic [1:0] bpp_ff, bpp_in;
   logic       reg_sel;

   assign reg_sel    = csr_paddr[CSR_ADDR_BITS-1];
   assign csr_pready = 1'b1;
   assign bpp_code   = bpp_ff;

   always_comb begin
      bpp_in = bpp_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel == REG_BPP) begin
         bpp_in = csr_pwdata[1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel == REG_BPP) begin
         csr_prdata = {{(CSR_DATA_BITS-2){1'b0}}, bpp_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= BPP_CODE_RST;
      end else begin
         bpp_ff <= bpp_in;
      end
   end

endmodule

// ===== rtl/ppu_seq.sv =====
`include "packed_pixel_palette_unpacker_unit_macros.svh"

module ppu_seq import ppu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ppu_req_if.sink     req_if,
   input  logic [1:0]  bpp_code,
   input  logic        issue_ok,
   output rd_req_type  rd,
   output wr_req_type  wr
);

   logic                  seq_valid_ff, seq_valid_in;
   logic [DATA_BITS-1:0]  seq_byte_ff, seq_byte_in;
   logic [PAL_BITS-1:0]   seq_pal_ff, seq_pal_in;
   logic [1:0]            seq_code_ff, seq_code_in;
   logic [LEFT_BITS-1:0]  seq_left_ff, seq_left_in;

   logic                  issue, last, accept;
   logic [FIELD_BITS-1:0] field;

   assign issue  = seq_valid_ff && issue_ok;
   assign last   = seq_left_ff == LEFT_BITS'(1);
   assign req_if.ready = !seq_valid_ff || (issue && last);
   assign accept = req_if.valid && req_if.ready;
   assign field  = top_field(seq_byte_ff, seq_code_ff);

   // one palette read per cycle while issue_ok is high, most significant field first
   always_comb begin
      rd.valid = issue;
      rd.addr  = ADDR_BITS'(32'(seq_pal_ff) * ENTRY_COUNT + 32'(field));
      rd.zero  = (32'(seq_pal_ff) >= PALETTE_COUNT) || (32'(field) >= ENTRY_COUNT);
      rd.last  = last;
   end

   always_comb begin
      wr.en   = accept && req_if.command == CMD_LOAD
                && 32'(req_if.palette_select) < PALETTE_COUNT
                && 32'(req_if.entry_index) < ENTRY_COUNT;
      wr.addr = ADDR_BITS'(32'(req_if.palette_select) * ENTRY_COUNT
                           + 32'(req_if.entry_index));
      wr.data = req_if.entry_value;
   end

   always_comb begin
      seq_valid_in = seq_valid_ff;
      seq_byte_in  = seq_byte_ff;
      seq_pal_in   = seq_pal_ff;
      seq_code_in  = seq_code_ff;
      seq_left_in  = seq_left_ff;
      if (accept && req_if.command == CMD_PIXEL) begin
         seq_valid_in = 1'b1;
         seq_byte_in  = req_if.packed_byte;
         seq_pal_in   = req_if.palette_select;
         seq_code_in  = bpp_code;
         seq_left_in  = bpp_count(bpp_code);
      end else if (issue) begin
         seq_valid_in = !last;
         seq_byte_in  = seq_byte_ff << bpp_width(seq_code_ff);
         seq_left_in  = seq_left_ff - LEFT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
      end else begin
         seq_valid_ff <= seq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_byte_ff <= seq_byte_in;
      seq_pal_ff  <= seq_pal_in;
      seq_code_ff <= seq_code_in;
      seq_left_ff <= seq_left_in;
   end

   `PPU_ASSERT(a_left_range, clock, reset, (seq_valid_ff |-> (seq_left_ff != '0 && seq_left_ff <= LEFT_BITS'(8))))
   `PPU_ASSERT(a_done_idle, clock, reset, ((issue && last && !accept) |=> !seq_valid_ff))
   `PPU_ASSERT(a_load_ordered, clock, reset, (wr.en |-> (!seq_valid_ff || (issue && last))))
   `PPU_ASSERT_ALWAYS(a_reset_idle, clock, (reset |=> !seq_valid_ff))

endmodule

// ===== rtl/ppu_store.sv =====
module ppu_store import ppu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rd_req_type  rd,
   input  wr_req_type  wr,
   output logic        issue_ok,
   ppu_rsp_if.source   rsp_if
);

   logic [DATA_BITS-1:0] mem [STORE_DEPTH];

   logic [DATA_BITS-1:0] rdata_ff;
   logic                 m_valid_ff, m_valid_in;
   logic                 m_zero_ff, m_last_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign issue_ok = !m_valid_ff || out_free;

   // read-first: a read in the cycle of a write sees the older contents
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.valid) begin
         rdata_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd.valid) begin
         m_zero_ff <= rd.zero;
         m_last_ff <= rd.last;
      end
   end

   always_comb begin
      m_valid_in = m_valid_ff;
      if (rd.valid) begin
         m_valid_in = 1'b1;
      end else if (out_free) begin
         m_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = m_valid_ff;
         rsp_color_in = m_zero_ff ? '0 : rdata_ff;
         rsp_last_in  = m_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pixel_color  = rsp_color_ff;
   assign rsp_if.last_of_byte = rsp_last_ff;

endmodule

// ===== rtl/packed_pixel_palette_unpacker_unit.sv =====
// Packed pixel palette unpacker.
// req_if carries requests: command 0 loads palette_select/entry_index with
// entry_value, command 1 unpacks packed_byte through palette palette_select.
// rsp_if returns one pixel_color per field, high field first, with
// last_of_byte set on the final pixel of each byte.
// csr_* is an APB write/read port; register 0 (bits_per_pixel_code) selects
// 1, 2 or 4 bits per pixel (code 3 acts as 4). Write it only while idle.
// Throughput: one pixel per cycle while rsp_if does not stall, set by the
// single read port of the 4096 x 8 palette RAM; a byte yields 8/bpp pixels
// (2 at 4 bpp, 8 at 1 bpp). A load produces no response.
// The first pixel of a byte passes through the sequencer, the RAM read stage
// and the output register before it is valid on rsp_if.
// Reset clears the pipeline and sets 4 bits per pixel; the palette RAM is
// not cleared and must be loaded before use.
// When rsp_if stalls, the output register and the RAM read stage hold and
// the sequencer stops issuing reads; req_if.ready stays low while a byte is
// being unpacked, until the cycle its last read issues.
module packed_pixel_palette_unpacker_unit import ppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   ppu_req_if.sink                  req_if,
   ppu_rsp_if.source                rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [1:0] bpp_code;
   logic       issue_ok;
   rd_req_type rd;
   wr_req_type wr;

   ppu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bpp_code    (bpp_code)
   );

   ppu_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .bpp_code (bpp_code),
      .issue_ok (issue_ok),
      .rd       (rd),
      .wr       (wr)
   );

   ppu_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd       (rd),
      .wr       (wr),
      .issue_ok (issue_ok),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import ppu_pkg::*;

   localparam int STALL_MAX      = 14;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_REQUESTS = 30;
   localparam int POOL_SIZE      = 6;

   localparam logic [1:0] BPP_CODE_WIDE = 2'd3;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_BPP   = {REG_BPP, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SPARE = {~REG_BPP, 2'b00};

   typedef struct packed {
      logic                  command;
      logic [PAL_BITS-1:0]   palette_select;
      logic [INDEX_BITS-1:0] entry_index;
      logic [DATA_BITS-1:0]  entry_value;
      logic [DATA_BITS-1:0]  packed_byte;
   } request_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] pixel_color;
      logic                 last_of_byte;
   } pixel_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   ppu_req_if req_if ();
   ppu_rsp_if rsp_if ();

   packed_pixel_palette_unpacker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [DATA_BITS-1:0] palette_copy [STORE_DEPTH];
   bit                   entry_loaded [STORE_DEPTH];
   logic [1:0]           bpp_code_copy;
   pixel_type            pending_pixels [$];
   logic [PAL_BITS-1:0]  palette_pool [POOL_SIZE];

   int  errors          = 0;
   int  requests_sent   = 0;
   int  loads_sent      = 0;
   int  pixels_seen     = 0;
   int  idle_cycles     = 0;
   int  rsp_hold_cycles = 0;
   bit  req_gaps_on     = 1'b1;
   bit  rsp_gaps_on     = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pixel_bits(input logic [1:0] code);
      case (code)
         BPP_CODE_1: return 1;
         BPP_CODE_2: return 2;
         default:    return 4;
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] field_at(input logic [DATA_BITS-1:0] b,
                                                      input int k);
      int w;
      int n;
      w = pixel_bits(bpp_code_copy);
      n = 8 / w;
      return FIELD_BITS'((b >> ((n - 1 - k) * w)) & ((1 << w) - 1));
   endfunction

   function automatic void predict_request(input request_type r);
      int                    n;
      int                    k;
      logic [FIELD_BITS-1:0] f;
      pixel_type             px;
      if (r.command == CMD_LOAD) begin
         palette_copy[{r.palette_select, r.entry_index}] = r.entry_value;
         entry_loaded[{r.palette_select, r.entry_index}] = 1'b1;
         loads_sent++;
      end else begin
         n = 8 / pixel_bits(bpp_code_copy);
         for (k = 0; k < n; k++) begin
            f               = field_at(r.packed_byte, k);
            px.pixel_color  = palette_copy[{r.palette_select, f}];
            px.last_of_byte = (k == n - 1);
            pending_pixels  = {pending_pixels, px};
         end
      end
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("mismatch %s: expected %0h, actual %0h", what, want, got);
   endtask

   task automatic send_request(input request_type r);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.command        <= r.command;
      req_if.palette_select <= r.palette_select;
      req_if.entry_index    <= r.entry_index;
      req_if.entry_value    <= r.entry_value;
      req_if.packed_byte    <= r.packed_byte;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_request(r);
      requests_sent++;
   endtask

   task automatic send_load(input logic [PAL_BITS-1:0] pal, input logic [INDEX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] val);
      request_type r;
      r.command        = CMD_LOAD;
      r.palette_select = pal;
      r.entry_index    = idx;
      r.entry_value    = val;
      r.packed_byte    = DATA_BITS'($urandom_range(0, 255));
      send_request(r);
   endtask

   // loads any entry the byte would touch that has not been written yet
   task automatic send_pixel(input logic [PAL_BITS-1:0] pal, input logic [DATA_BITS-1:0] b);
      request_type           r;
      logic [FIELD_BITS-1:0] f;
      int                    k;
      for (k = 0; k < 8 / pixel_bits(bpp_code_copy); k++) begin
         f = field_at(b, k);
         if (!entry_loaded[{pal, f}])
            send_load(pal, f, DATA_BITS'($urandom_range(0, 255)));
      end
      r.command        = CMD_PIXEL;
      r.palette_select = pal;
      r.entry_index    = INDEX_BITS'($urandom_range(0, 15));
      r.entry_value    = DATA_BITS'($urandom_range(0, 255));
      r.packed_byte    = b;
      send_request(r);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (addr[CSR_ADDR_BITS-1:2] == REG_BPP)
         bpp_code_copy = data[1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check_bpp();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_BPP;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_BITS'(bpp_code_copy))
         note_mismatch("bits_per_pixel_code read", CSR_DATA_BITS'(bpp_code_copy), csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // upper bits are junk on purpose, only the low two are kept
   task automatic set_bpp(input logic [1:0] code);
      csr_write(ADDR_BPP, {30'($urandom()), code});
      csr_check_bpp();
   endtask

   // result checker
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            note_mismatch("unexpected pixel", '0,
                          32'({rsp_if.pixel_color, rsp_if.last_of_byte}));
         end else begin
            want = pending_pixels.pop_front();
            if (want.pixel_color !== rsp_if.pixel_color)
               note_mismatch("pixel_color", 32'(want.pixel_color), 32'(rsp_if.pixel_color));
            if (want.last_of_byte !== rsp_if.last_of_byte)
               note_mismatch("last_of_byte", 32'(want.last_of_byte),
                             32'(rsp_if.last_of_byte));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // pixel receiver, with a one-off long hold-off when asked
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid === 1'b1 && !reset));
      end
   end

   task automatic test_reset_values();
      csr_check_bpp();
   endtask

   task automatic test_register_writes();
      csr_write(ADDR_BPP, '1);
      csr_check_bpp();
      csr_write(ADDR_SPARE, $urandom());
      csr_check_bpp();
      set_bpp(BPP_CODE_1);
      set_bpp(BPP_CODE_4);
   endtask

   task automatic test_directed_pixels();
      int i;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      for (i = 0; i < ENTRY_COUNT; i++)
         send_load(8'h00, INDEX_BITS'(i), (i == 0) ? 8'h00 : (i == ENTRY_COUNT - 1) ? 8'hFF
                                               : 8'($urandom_range(0, 255)));
      send_load(8'hFF, 4'd0, 8'hFF);
      send_load(8'hFF, 4'd1, 8'h00);
      send_load(8'hFF, 4'd2, 8'hA5);
      send_load(8'hFF, 4'd3, 8'h5A);
      send_pixel(8'h00, 8'h0F);
      send_pixel(8'h00, 8'hF0);
      send_pixel(8'hFF, 8'h00);
      settle();
      set_bpp(BPP_CODE_1);
      send_pixel(8'hFF, 8'hA5);
      send_pixel(8'h00, 8'hFF);
      settle();
      set_bpp(BPP_CODE_2);
      send_pixel(8'hFF, 8'h1B);
      settle();
      set_bpp(BPP_CODE_WIDE);
      send_pixel(8'h00, 8'hE4);
      settle();
   endtask

   task automatic test_random_traffic();
      logic [1:0]          codes [4];
      logic [PAL_BITS-1:0] pal;
      int                  phase;
      int                  start;
      int                  i;
      codes = '{BPP_CODE_4, BPP_CODE_1, BPP_CODE_2, BPP_CODE_WIDE};
      palette_pool[0] = 8'h00;
      palette_pool[1] = 8'hFF;
      for (i = 2; i < POOL_SIZE; i++)
         palette_pool[i] = PAL_BITS'($urandom_range(0, 255));
      for (phase = 0; phase < 4; phase++) begin
         set_bpp(codes[phase]);
         req_gaps_on = (phase != 1);
         rsp_gaps_on = (phase != 2);
         start = requests_sent;
         while (requests_sent - start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 99) < 85)
               pal = palette_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               pal = PAL_BITS'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 35)
               send_load(pal, INDEX_BITS'($urandom_range(0, 15)),
                         DATA_BITS'($urandom_range(0, 255)));
            else
               send_pixel(pal, DATA_BITS'($urandom_range(0, 255)));
         end
         settle();
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      int i;
      set_bpp(BPP_CODE_1);
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (i = 0; i < 24; i++)
         send_pixel(palette_pool[$urandom_range(0, POOL_SIZE - 1)],
                    DATA_BITS'($urandom_range(0, 255)));
      settle();
      req_gaps_on = 1'b1;
   endtask

   initial begin
      req_if.valid          = 1'b0;
      req_if.command        = CMD_LOAD;
      req_if.palette_select = '0;
      req_if.entry_index    = '0;
      req_if.entry_value    = '0;
      req_if.packed_byte    = '0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      bpp_code_copy         = BPP_CODE_RST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_writes();
      test_directed_pixels();
      test_random_traffic();
      test_output_backpressure();
      settle();

      if (pending_pixels.size() != 0) begin
         $display("%0d expected pixels never returned", pending_pixels.size());
         errors += pending_pixels.size();
      end
      $display("%0d requests (%0d palette loads), %0d pixels checked at 1, 2 and 4 bpp",
               requests_sent, loads_sent, pixels_seen);
      $display("register writes incl. code 3 and spare address; %0d-cycle output stall; %0d errors",
               HOLD_CYCLES, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
